### hw/rtl/adlm_pkg.sv
// shared constants, types and helpers for the allow/deny list matcher
`timescale 1ns / 1ps
package adlm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int NAME_BYTES  = 32;
  localparam int SEG_MAX     = NAME_BYTES - 1;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W       = $clog2(NAME_BYTES);
  localparam int LEN_W       = $clog2(SEG_MAX + 1);
  localparam int ID_AW       = IDX_W + 1;
  localparam int NM_AW       = IDX_W + POS_W + 1;
  localparam int ID_W        = 64;

  typedef enum logic [2:0] {
    OP_SET_COUNT = 3'd0,
    OP_WRITE_ID  = 3'd1,
    OP_WRITE_CH  = 3'd2,
    OP_ID_QUERY  = 3'd3,
    OP_NAME_BYTE = 3'd4
  } opcode_t;

  localparam logic [1:0] VERDICT_NONE  = 2'b00;
  localparam logic [1:0] VERDICT_ALLOW = 2'b01;
  localparam logic [1:0] VERDICT_DENY  = 2'b11;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_CASE    = 8'h20;

  // request to the shared compare unit
  typedef struct packed {
    logic            wide;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
  } cmp_req_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CH_CASE;
    end
    return c;
  endfunction

endpackage

### hw/rtl/adlm_cmp_unit.sv
// shared equality unit for id words and name bytes
`timescale 1ns / 1ps
module adlm_cmp_unit
  import adlm_pkg::*;
(
  input  cmp_req_t req,
  output logic     eq
);

  always_comb begin
    if (req.wide) begin
      eq = (req.a == req.b);
    end else begin
      eq = (req.a[7:0] == req.b[7:0]);
    end
  end

endmodule

### hw/rtl/allow_deny_list_matcher.sv
// allow/deny list matcher: tables, path segment buffer and scan sequencer
//
//   channel   dir  signals                          moves
//   s_*       in   tvalid tready tdata tuser tlast  one command or query byte
//   m_*       out  tvalid tready tdata              one verdict
//
// after reset the tables are swept to zero, not ready meanwhile.
// setting a count sweeps that list's half.
// id query: each scanned entry passes S_NEXT, S_ID_RD and S_ID_CMP via the id table read port.
// name query: per entry each stored name byte is read in S_NM_RD and S_NM_LD, then
// each containment test compares byte by byte, all through the one compare unit.
// a verdict waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module allow_deny_list_matcher
  import adlm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index, entry_count, id_value, char_position, char_value, zero pad
  input  logic [95:0] s_tdata,
  // opcode, list_select
  input  logic [3:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // verdict, zero pad
  output logic [7:0]  m_tdata
);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_NEXT     = 10'b0000000100,
    S_ID_RD    = 10'b0000001000,
    S_ID_CMP   = 10'b0000010000,
    S_NM_RD    = 10'b0000100000,
    S_NM_LD    = 10'b0001000000,
    S_CMP_INIT = 10'b0010000000,
    S_CMP      = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state;

  // request fields
  logic [2:0]       opcode;
  logic             list_select;
  logic [IDX_W-1:0] entry_index;
  logic [CNT_W-1:0] entry_count;
  logic [ID_W-1:0]  id_value;
  logic [POS_W-1:0] char_position;
  logic [7:0]       char_value;
  logic             accept;

  assign opcode        = s_tuser[2:0];
  assign list_select   = s_tuser[3];
  assign entry_index   = s_tdata[5:0];
  assign entry_count   = s_tdata[12:6];
  assign id_value      = s_tdata[76:13];
  assign char_position = s_tdata[81:77];
  assign char_value    = s_tdata[89:82];
  assign s_tready      = (state == S_IDLE);
  assign accept        = s_tvalid && s_tready;

  // tables
  logic [ID_W-1:0] id_mem [2*MAX_ENTRIES];
  logic [7:0]      name_mem [2*MAX_ENTRIES*NAME_BYTES];
  logic [ID_W-1:0] id_rd;
  logic [7:0]      nm_rd;
  logic [CNT_W-1:0] counts [2];

  logic [NM_AW-1:0] clr_addr;
  logic [NM_AW-1:0] clr_end;

  // segment and scan registers
  logic [7:0]       seg [SEG_MAX];
  logic [LEN_W-1:0] seg_len;
  logic             path_seen;
  logic [7:0]       ent [SEG_MAX];
  logic [LEN_W-1:0] ent_len;

  logic             scan_list;
  logic             scan_name;
  logic [CNT_W-1:0] ent_i;
  logic [POS_W-1:0] k;
  logic [POS_W-1:0] s;
  logic             dir;
  logic [ID_W-1:0]  query_id;
  logic [1:0]       result;

  // memory write port
  logic             id_we;
  logic [ID_AW-1:0] id_waddr;
  logic [ID_W-1:0]  id_wdata;
  logic             nm_we;
  logic [NM_AW-1:0] nm_waddr;
  logic [7:0]       nm_wdata;

  always_comb begin
    id_we    = 1'b0;
    id_waddr = {list_select, entry_index};
    id_wdata = id_value;
    nm_we    = 1'b0;
    nm_waddr = {list_select, entry_index, char_position};
    nm_wdata = char_value;
    if (state == S_CLEAR) begin
      nm_we    = 1'b1;
      nm_waddr = clr_addr;
      nm_wdata = 8'h00;
      id_we    = 1'b1;
      id_waddr = clr_addr[NM_AW-1:POS_W];
      id_wdata = '0;
    end else if (accept && opcode == OP_WRITE_ID) begin
      id_we = 1'b1;
    end else if (accept && opcode == OP_WRITE_CH
                 && char_position < POS_W'(SEG_MAX)) begin
      nm_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
    id_rd <= id_mem[{scan_list, ent_i[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      name_mem[nm_waddr] <= nm_wdata;
    end
    nm_rd <= name_mem[{scan_list, ent_i[IDX_W-1:0], k}];
  end

  // containment test operands
  logic [LEN_W-1:0] hl;
  logic [LEN_W-1:0] nl;
  logic [POS_W-1:0] hidx;
  logic [POS_W-1:0] ent_idx;
  logic [POS_W-1:0] seg_idx;
  logic [7:0]       ent_byte;
  logic [7:0]       seg_byte;

  assign hl      = dir ? seg_len : ent_len;
  assign nl      = dir ? ent_len : seg_len;
  assign hidx    = POS_W'(s + k);
  assign ent_idx = dir ? k : hidx;
  assign seg_idx = dir ? hidx : k;
  assign ent_byte = ent[ent_idx];
  assign seg_byte = seg[seg_idx];

  cmp_req_t cmp_req;
  logic     cmp_eq;

  always_comb begin
    cmp_req.wide = (state == S_ID_CMP);
    cmp_req.a    = (state == S_ID_CMP) ? id_rd : {56'd0, ent_byte};
    cmp_req.b    = (state == S_ID_CMP) ? query_id : {56'd0, seg_byte};
  end

  adlm_cmp_unit u_cmp (
    .req (cmp_req),
    .eq  (cmp_eq)
  );

  logic [1:0] hit_verdict;
  logic       path_seen_next;
  logic       is_sep;

  assign hit_verdict    = scan_list ? VERDICT_DENY : VERDICT_ALLOW;
  assign path_seen_next = path_seen || (char_value != 8'h00);
  assign is_sep         = (char_value == CH_SLASH) || (char_value == CH_BSLASH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_end   <= '1;
      counts[0] <= '0;
      counts[1] <= '0;
      seg_len   <= '0;
      path_seen <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == clr_end) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_SET_COUNT: begin
                if (entry_count <= CNT_W'(MAX_ENTRIES)) begin
                  counts[list_select] <= entry_count;
                  clr_addr <= {list_select, {(NM_AW-1){1'b0}}};
                  clr_end  <= {list_select, {(NM_AW-1){1'b1}}};
                  state    <= S_CLEAR;
                end
              end
              OP_ID_QUERY: begin
                query_id  <= id_value;
                scan_name <= 1'b0;
                scan_list <= 1'b1;
                ent_i     <= '0;
                if (!id_value[ID_W-1] && id_value != '0) begin
                  state <= S_NEXT;
                end else begin
                  result <= VERDICT_NONE;
                  state  <= S_DONE;
                end
              end
              OP_NAME_BYTE: begin
                if (char_value != 8'h00) begin
                  path_seen <= 1'b1;
                  if (is_sep) begin
                    seg_len <= '0;
                  end else if (seg_len < LEN_W'(SEG_MAX)) begin
                    seg[seg_len[POS_W-1:0]] <= to_lower(char_value);
                    seg_len <= seg_len + 1'b1;
                  end
                end
                if (s_tlast) begin
                  scan_name <= 1'b1;
                  scan_list <= 1'b1;
                  ent_i     <= '0;
                  if (path_seen_next) begin
                    state <= S_NEXT;
                  end else begin
                    result <= VERDICT_NONE;
                    state  <= S_DONE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_NEXT: begin
          if (ent_i >= counts[scan_list]) begin
            if (scan_list) begin
              scan_list <= 1'b0;
              ent_i     <= '0;
            end else begin
              result <= VERDICT_NONE;
              state  <= S_DONE;
            end
          end else if (scan_name) begin
            k     <= '0;
            state <= S_NM_RD;
          end else begin
            state <= S_ID_RD;
          end
        end
        S_ID_RD: begin
          state <= S_ID_CMP;
        end
        S_ID_CMP: begin
          if (cmp_eq) begin
            result <= hit_verdict;
            state  <= S_DONE;
          end else begin
            ent_i <= ent_i + 1'b1;
            state <= S_NEXT;
          end
        end
        S_NM_RD: begin
          state <= S_NM_LD;
        end
        S_NM_LD: begin
          dir <= 1'b0;
          if (nm_rd == 8'h00) begin
            ent_len <= LEN_W'(k);
            state   <= S_CMP_INIT;
          end else begin
            ent[k] <= to_lower(nm_rd);
            if (k == POS_W'(SEG_MAX - 1)) begin
              ent_len <= LEN_W'(SEG_MAX);
              state   <= S_CMP_INIT;
            end else begin
              k     <= k + 1'b1;
              state <= S_NM_RD;
            end
          end
        end
        S_CMP_INIT: begin
          s <= '0;
          k <= '0;
          if (nl == '0) begin
            result <= hit_verdict;
            state  <= S_DONE;
          end else if (nl > hl) begin
            if (!dir) begin
              dir <= 1'b1;
            end else begin
              ent_i <= ent_i + 1'b1;
              state <= S_NEXT;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmp_eq) begin
            if (LEN_W'(k) == nl - 1'b1) begin
              result <= hit_verdict;
              state  <= S_DONE;
            end else begin
              k <= k + 1'b1;
            end
          end else if ({1'b0, s} + {1'b0, nl} == {1'b0, hl}) begin
            // this direction found nothing
            if (!dir) begin
              dir   <= 1'b1;
              state <= S_CMP_INIT;
            end else begin
              ent_i <= ent_i + 1'b1;
              state <= S_NEXT;
            end
          end else begin
            s <= s + 1'b1;
            k <= '0;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, result};
            state    <= S_IDLE;
            if (scan_name) begin
              seg_len   <= '0;
              path_seen <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) seg_len <= LEN_W'(SEG_MAX))
    else $error("segment length overflow");

  assert property (@(posedge clk) disable iff (rst)
    counts[0] <= CNT_W'(MAX_ENTRIES) && counts[1] <= CNT_W'(MAX_ENTRIES))
    else $error("list count out of range");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'b10 && m_tdata[7:2] == 6'd0)
    else $error("bad verdict code");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("request taken during table sweep");

endmodule

### bench/testbench.sv
// self-checking testbench for the allow/deny list matcher
`timescale 1ns / 1ps
module testbench;
  import adlm_pkg::*;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        list_sel;
    logic [5:0]  entry_idx;
    logic [6:0]  entry_cnt;
    logic [63:0] id_val;
    logic [4:0]  char_pos;
    logic [7:0]  char_val;
    logic        name_last;
  } request_t;

  typedef logic [7:0] seg_t [SEG_MAX];

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int STALL_LEN      = 6000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  allow_deny_list_matcher uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow tables and path segment state
  logic [63:0] id_tab [2*MAX_ENTRIES];
  logic [7:0]  name_tab [2*MAX_ENTRIES][NAME_BYTES];
  int          list_cnt [2];
  seg_t        seg_buf;
  int          seg_len;
  bit          path_seen;

  request_t    pending_requests [$];
  logic [1:0]  expected_verdicts [$];
  request_t    cur_req;
  int          send_gap;
  int          recv_gap;
  int          long_stall;
  bit          stall_done;
  int          n_accepted, n_checked, n_mismatch, idle_cycles;
  int          n_deny, n_allow, n_none;

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit holds(input seg_t hay, input int hl, input seg_t nd, input int nl);
    int s, k;
    bit ok;
    if (nl == 0) return 1'b1;
    for (s = 0; s + nl <= hl; s++) begin
      ok = 1'b1;
      for (k = 0; k < nl; k++) if (hay[s+k] != nd[k]) ok = 1'b0;
      if (ok) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit id_listed(input int lst, input logic [63:0] id);
    for (int i = 0; i < list_cnt[lst]; i++)
      if (id_tab[lst*MAX_ENTRIES+i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit name_listed(input int lst);
    seg_t ent;
    int k;
    for (int i = 0; i < list_cnt[lst]; i++) begin
      ent = '{default: 8'h00};
      for (k = 0; k < SEG_MAX && name_tab[lst*MAX_ENTRIES+i][k] != 8'h00; k++)
        ent[k] = lower_byte(name_tab[lst*MAX_ENTRIES+i][k]);
      if (holds(ent, k, seg_buf, seg_len) || holds(seg_buf, seg_len, ent, k)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void tables_clear();
    for (int i = 0; i < 2*MAX_ENTRIES; i++) begin
      id_tab[i] = '0;
      for (int k = 0; k < NAME_BYTES; k++) name_tab[i][k] = 8'h00;
    end
    list_cnt = '{0, 0};
    seg_len = 0;
    path_seen = 1'b0;
  endfunction

  // update the shadow state for one accepted request, queue its verdict
  function automatic void predict_verdict(input request_t r);
    int base;
    logic [1:0] v;
    base = r.list_sel * MAX_ENTRIES;
    v = VERDICT_NONE;
    case (r.opcode)
      OP_SET_COUNT: if (r.entry_cnt <= MAX_ENTRIES) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          id_tab[base+i] = '0;
          for (int k = 0; k < NAME_BYTES; k++) name_tab[base+i][k] = 8'h00;
        end
        list_cnt[r.list_sel] = r.entry_cnt;
      end
      OP_WRITE_ID: id_tab[base+r.entry_idx] = r.id_val;
      OP_WRITE_CH: if (r.char_pos < SEG_MAX) name_tab[base+r.entry_idx][r.char_pos] = r.char_val;
      OP_ID_QUERY: begin
        if (!r.id_val[63] && r.id_val != 0) begin
          if (id_listed(1, r.id_val)) v = VERDICT_DENY;
          else if (id_listed(0, r.id_val)) v = VERDICT_ALLOW;
        end
        expected_verdicts.push_back(v);
      end
      OP_NAME_BYTE: begin
        if (r.char_val != 8'h00) begin
          path_seen = 1'b1;
          if (r.char_val == CH_SLASH || r.char_val == CH_BSLASH) seg_len = 0;
          else if (seg_len < SEG_MAX) begin
            seg_buf[seg_len] = lower_byte(r.char_val);
            seg_len++;
          end
        end
        if (r.name_last) begin
          if (path_seen) begin
            if (name_listed(1)) v = VERDICT_DENY;
            else if (name_listed(0)) v = VERDICT_ALLOW;
          end
          seg_len = 0;
          path_seen = 1'b0;
          expected_verdicts.push_back(v);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.opcode    = 3'($urandom);
    r.list_sel  = 1'($urandom);
    r.entry_idx = 6'($urandom);
    r.entry_cnt = 7'($urandom);
    r.id_val    = {$urandom, $urandom};
    r.char_pos  = 5'($urandom);
    r.char_val  = 8'($urandom);
    r.name_last = 1'($urandom);
    return r;
  endfunction

  task automatic add(input logic [2:0] op, input bit lst, input int idx, input int cnt,
                     input logic [63:0] id, input int pos, input logic [7:0] ch, input bit last);
    request_t r;
    r = noise_request();
    r.opcode = op;
    r.list_sel = lst;
    r.entry_idx = 6'(idx);
    r.entry_cnt = 7'(cnt);
    r.id_val = id;
    r.char_pos = 5'(pos);
    r.char_val = ch;
    r.name_last = last;
    pending_requests.push_back(r);
  endtask

  task automatic add_name(input bit lst, input int idx, input string s);
    for (int k = 0; k < s.len() && k < SEG_MAX; k++) add(OP_WRITE_CH, lst, idx, 0, 0, k, s[k], 0);
    if (s.len() < SEG_MAX) add(OP_WRITE_CH, lst, idx, 0, 0, s.len(), 8'h00, 0);
  endtask

  task automatic add_path(input string s);
    for (int k = 0; k < s.len(); k++) add(OP_NAME_BYTE, 0, 0, 0, 0, 0, s[k], k == s.len() - 1);
  endtask

  function automatic string pick_word();
    string words [8];
    string w;
    words = '{"cmd", "Note", "svc", "HOST.exe", "a", "Calc", "xYz", "notepad"};
    w = words[$urandom_range(0, 7)];
    if ($urandom_range(0, 3) == 0) w = w.toupper();
    return w;
  endfunction

  function automatic logic [63:0] pick_id();
    logic [63:0] pool [6];
    pool = '{64'd5, 64'd42, -64'sd7, 64'd1000, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000};
    return ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : pool[$urandom_range(0, 5)];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    string path;
    int r, c;
    // directed part
    add(OP_SET_COUNT, 0, 0, 3, 0, 0, 0, 0);
    add(OP_SET_COUNT, 1, 0, 2, 0, 0, 0, 0);
    add(OP_SET_COUNT, 0, 0, 65, 0, 0, 0, 0);
    add(OP_SET_COUNT, 1, 0, 127, 0, 0, 0, 0);
    add(OP_WRITE_ID, 0, 0, 0, 5, 0, 0, 0);
    add(OP_WRITE_ID, 0, 2, 0, 42, 0, 0, 0);
    add(OP_WRITE_ID, 0, 63, 0, 99, 0, 0, 0);
    add(OP_WRITE_ID, 1, 1, 0, 42, 0, 0, 0);
    add(OP_WRITE_ID, 1, 0, 0, 64'h7fff_ffff_ffff_ffff, 0, 0, 0);
    add(OP_WRITE_CH, 1, 1, 0, 0, 31, "Q", 0);
    add_name(0, 0, "Note");
    add_name(1, 0, "CMD");
    add_name(1, 1, "abcdefghijklmnopqrstuvwxyz01234");
    add(OP_ID_QUERY, 0, 0, 0, 42, 0, 0, 0);
    add(OP_ID_QUERY, 0, 0, 0, 5, 0, 0, 0);
    add(OP_ID_QUERY, 0, 0, 0, 0, 0, 0, 0);
    add(OP_ID_QUERY, 0, 0, 0, -64'sd7, 0, 0, 0);
    add(OP_ID_QUERY, 0, 0, 0, 64'h7fff_ffff_ffff_ffff, 0, 0, 0);
    add(OP_ID_QUERY, 0, 0, 0, 99, 0, 0, 0);
    add_path("C:\\Win\\NOTEPAD.exe");
    add(OP_NAME_BYTE, 0, 0, 0, 0, 0, "x", 0);
    add(OP_ID_QUERY, 0, 0, 0, 5, 0, 0, 0);  // id query inside a name stream
    add_path("/cmd.exe");
    add_path("dir/");
    add(OP_NAME_BYTE, 0, 0, 0, 0, 0, 8'h00, 1);  // empty path
    add_path("zz/0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ");
    add(5, 0, 0, 0, 0, 0, 0, 1);
    add(6, 1, 0, 0, 0, 0, 0, 1);
    add(7, 1, 63, 64, 0, 30, 8'hff, 1);
    add(OP_SET_COUNT, 0, 0, 64, 0, 0, 0, 0);
    add_path("a/b/Calc");
    add(OP_ID_QUERY, 0, 0, 0, 42, 0, 0, 0);
    add(OP_SET_COUNT, 0, 0, 0, 0, 0, 0, 0);
    add(OP_ID_QUERY, 0, 0, 0, 5, 0, 0, 0);

    // random part, mostly well-formed table updates and queries
    while (pending_requests.size() < 2000) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        c = $urandom_range(0, 19);
        c = (c == 0) ? 64 : (c < 3) ? $urandom_range(65, 127) : $urandom_range(0, 8);
        add(OP_SET_COUNT, $urandom_range(0, 1), 0, c, 0, 0, 0, 0);
      end else if (r < 22) begin
        add(OP_WRITE_ID, $urandom_range(0, 1),
            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8),
            0, pick_id(), 0, 0, 0);
      end else if (r < 38) begin
        add_name($urandom_range(0, 1), $urandom_range(0, 8), pick_word());
      end else if (r < 43) begin
        add(OP_WRITE_CH, $urandom_range(0, 1), $urandom_range(0, 8), 0, 0,
            $urandom_range(0, 31), 8'($urandom), 0);
      end else if (r < 63) begin
        add(OP_ID_QUERY, 0, 0, 0, pick_id(), 0, 0, 0);
      end else if (r < 88) begin
        path = "";
        c = $urandom_range(1, 3);
        for (int k = 0; k < c; k++) begin
          path = {path, pick_word()};
          if (k < c - 1 || $urandom_range(0, 9) == 0) path = {path, $urandom_range(0, 1) ? "/" : "\\"};
        end
        if ($urandom_range(0, 9) == 0) path = {path, "_padding_to_overflow_the_segment"};
        add_path(path);
      end else if (r < 95) begin
        add(OP_NAME_BYTE, 0, 0, 0, 0, 0, 8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        pending_requests.push_back(noise_request());
      end
    end
    add(OP_NAME_BYTE, 0, 0, 0, 0, 0, "e", 1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_requests.size() == 0 && !s_tvalid);
    wait (expected_verdicts.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d requests accepted, %0d verdicts checked (deny %0d, allow %0d, none %0d)",
             n_accepted, n_checked, n_deny, n_allow, n_none);
    $display("%0d mismatches", n_mismatch);
    if (n_mismatch == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
      n_accepted = 0;
      tables_clear();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_verdict(cur_req);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_req = pending_requests.pop_front();
          s_tuser <= {cur_req.list_sel, cur_req.opcode};
          s_tdata <= {6'd0, cur_req.char_val, cur_req.char_pos, cur_req.id_val,
                      cur_req.entry_cnt, cur_req.entry_idx};
          s_tlast <= cur_req.name_last;
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // verdict receiver, with one long hold-off so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
      long_stall = 0;
      stall_done = 1'b0;
    end else if (!stall_done && n_accepted > 600) begin
      stall_done = 1'b1;
      long_stall = STALL_LEN;
      m_tready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall--;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  // verdict checker
  always @(posedge clk) begin
    logic [1:0] want;
    if (rst) begin
      n_checked = 0;
      n_mismatch = 0;
      n_deny = 0;
      n_allow = 0;
      n_none = 0;
    end else if (m_tvalid && m_tready) begin
      n_checked++;
      if (expected_verdicts.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected verdict %b", m_tdata[1:0]);
      end else begin
        want = expected_verdicts.pop_front();
        case (want)
          VERDICT_DENY:  n_deny++;
          VERDICT_ALLOW: n_allow++;
          default:       n_none++;
        endcase
        if (m_tdata[1:0] !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("verdict %0d: expected %b, got %b", n_checked, want, m_tdata[1:0]);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
